### design/lru_write_back_cache_unit_macros.svh
// Assertion macros used by the cache unit's sequencer (lwbc_ctrl).
`ifndef LRU_WRITE_BACK_CACHE_UNIT_MACROS_SVH
`define LRU_WRITE_BACK_CACHE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define LWBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Property whose consequent is checked in the clock cycle after its antecedent.
`define LWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define LWBC_ASSERT(lbl, prop, msg)
`define LWBC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/lwbc_pkg.sv
// Shared constants, types and codes of the LRU write-back cache unit.
`default_nettype none

package lwbc_pkg;

  // Geometry.
  localparam int WAYS      = 16;
  localparam int MEM_DEPTH = 1024;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W    = $clog2(WAYS + 1);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Field widths.
  localparam int ADDR_W      = 10;
  localparam int DATA_W      = 32;
  localparam int WAYS_CFG_W  = 5;
  localparam int WORDS_CFG_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0]   REG_WAYS_IN_USE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]   REG_WORDS_IN_USE = CFG_IDX_W'(1);
  localparam logic [WAYS_CFG_W-1:0]  WAYS_RESET       = WAYS_CFG_W'(16);
  localparam logic [WORDS_CFG_W-1:0] WORDS_RESET      = WORDS_CFG_W'(1024);

  // Operation and status codes.
  localparam logic OP_READ     = 1'b0;
  localparam logic OP_WRITE    = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOB  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL
  } state_e;

  // Request and result payloads.
  typedef struct packed {
    logic                     operation;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     status;
  } rsp_t;

  // Commands from the sequencer to the entry store.
  typedef struct packed {
    logic              promote;
    logic [WAY_W-1:0]  prom_pos;
    logic [WAY_W-1:0]  prom_slot;
    logic              entry_we;
    logic [WAY_W-1:0]  wr_slot;
    logic [ADDR_W-1:0] wr_address;
    logic [DATA_W-1:0] wr_data;
    logic [WAY_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] key;
  } st_cmd_t;

  // Entry seen at the selected recency position.
  typedef struct packed {
    logic [WAY_W-1:0]  slot;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              match;
  } st_rsp_t;

  // Backing memory port.
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_cmd_t;

endpackage

`default_nettype wire

### design/lwbc_ram.sv
// Single-port backing memory with registered read data.
`default_nettype none

module lwbc_ram (
  input  wire logic                        clk_i,
  input  wire lwbc_pkg::ram_cmd_t          cmd_i,
  output logic [lwbc_pkg::DATA_W-1:0]      rdata_o
);

  logic [lwbc_pkg::DATA_W-1:0] mem [lwbc_pkg::MEM_DEPTH];
  logic [lwbc_pkg::DATA_W-1:0] rdata_q;

  // A read every cycle, plus a write when we is set, both at the same address; the read returns the old word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.addr] <= cmd_i.wdata;
    end
    rdata_q <= mem[cmd_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/lwbc_store.sv
// Cache entries, recency list and the shared address comparator.
`default_nettype none

module lwbc_store (
  input  wire logic              clk_i,
  input  wire lwbc_pkg::st_cmd_t cmd_i,
  output lwbc_pkg::st_rsp_t      rsp_o
);

  logic [lwbc_pkg::ADDR_W-1:0] addr_q  [lwbc_pkg::WAYS];
  logic [lwbc_pkg::DATA_W-1:0] data_q  [lwbc_pkg::WAYS];
  logic [lwbc_pkg::WAY_W-1:0]  order_q [lwbc_pkg::WAYS];
  logic [lwbc_pkg::WAY_W-1:0]  slot;

  // Entry write: address and data of one slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.entry_we) begin
      addr_q[cmd_i.wr_slot] <= cmd_i.wr_address;
      data_q[cmd_i.wr_slot] <= cmd_i.wr_data;
    end
  end

  // Promotion shifts positions up to prom_pos down by one and puts the slot in front.
  always_ff @(posedge clk_i) begin
    if (cmd_i.promote) begin
      order_q[0] <= cmd_i.prom_slot;
      for (int k = 1; k < lwbc_pkg::WAYS; k++) begin
        if (lwbc_pkg::WAY_W'(k) <= cmd_i.prom_pos) begin
          order_q[k] <= order_q[k-1];
        end
      end
    end
  end

  // One recency position is looked at per cycle.
  assign slot          = order_q[cmd_i.rd_pos];
  assign rsp_o.slot    = slot;
  assign rsp_o.address = addr_q[slot];
  assign rsp_o.data    = data_q[slot];
  assign rsp_o.match   = (addr_q[slot] == cmd_i.key);

endmodule

`default_nettype wire

### design/lwbc_ctrl.sv
// Sequencer: memory clear, recency scan, fill and write-back, configuration.
`default_nettype none
`include "lru_write_back_cache_unit_macros.svh"

module lwbc_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire lwbc_pkg::req_t                   req_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output lwbc_pkg::st_cmd_t                     st_cmd_o,
  input  wire lwbc_pkg::st_rsp_t                st_rsp_i,
  output lwbc_pkg::ram_cmd_t                    ram_cmd_o,
  input  wire logic [lwbc_pkg::DATA_W-1:0]      ram_rdata_i,
  output logic                                  done_o,
  output lwbc_pkg::rsp_t                        rsp_o
);

  lwbc_pkg::state_e                     state_q, state_d;
  lwbc_pkg::req_t                       req_q, req_d;
  lwbc_pkg::rsp_t                       rsp_q, rsp_d;
  logic [lwbc_pkg::FILL_W-1:0]          pos_q, pos_d;
  logic [lwbc_pkg::FILL_W-1:0]          fill_q, fill_d;
  logic [lwbc_pkg::MEM_AW-1:0]          clr_q, clr_d;
  logic                                 done_q, done_d;
  logic [lwbc_pkg::WAYS_CFG_W-1:0]      ways_q;
  logic [lwbc_pkg::WORDS_CFG_W-1:0]     words_q;
  logic                                 acc;
  logic                                 oob_in;
  logic                                 scan_end;
  logic                                 evict;
  logic                                 clr_last;
  logic [lwbc_pkg::WAY_W-1:0]           last_pos;
  logic [lwbc_pkg::DATA_W-1:0]          fresh;

  // Status of the current step.
  assign acc      = start && (state_q == lwbc_pkg::ST_IDLE);
  assign oob_in   = (32'(req_i.address) >= 32'(words_q)) ||
                    (32'(req_i.address) >= lwbc_pkg::MEM_DEPTH);
  assign scan_end = (pos_q == fill_q);
  assign evict    = (fill_q != '0) && ((32'(fill_q) >= 32'(ways_q)) ||
                                       (32'(fill_q) >= lwbc_pkg::WAYS));
  assign clr_last = (clr_q == lwbc_pkg::MEM_AW'(lwbc_pkg::MEM_DEPTH - 1));
  assign last_pos = lwbc_pkg::WAY_W'(fill_q - lwbc_pkg::FILL_W'(1));
  assign fresh    = (req_q.operation == lwbc_pkg::OP_WRITE) ? req_q.write_data : ram_rdata_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lwbc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = lwbc_pkg::ST_IDLE;
        end
      end
      lwbc_pkg::ST_IDLE: begin
        if (acc && !oob_in) begin
          state_d = lwbc_pkg::ST_SCAN;
        end
      end
      lwbc_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = lwbc_pkg::ST_FILL;
        end else if (st_rsp_i.match) begin
          state_d = lwbc_pkg::ST_IDLE;
        end
      end
      lwbc_pkg::ST_FILL: begin
        state_d = lwbc_pkg::ST_IDLE;
      end
      default: begin
        state_d = lwbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    busy                = (state_q != lwbc_pkg::ST_IDLE);
    st_cmd_o            = '0;
    st_cmd_o.rd_pos     = lwbc_pkg::WAY_W'(pos_q);
    st_cmd_o.key        = req_q.address;
    st_cmd_o.wr_address = req_q.address;
    ram_cmd_o.we        = 1'b0;
    ram_cmd_o.addr      = lwbc_pkg::MEM_AW'(req_q.address);
    ram_cmd_o.wdata     = '0;
    req_d               = req_q;
    rsp_d               = rsp_q;
    pos_d               = pos_q;
    fill_d              = fill_q;
    clr_d               = clr_q;
    done_d              = 1'b0;
    case (state_q)
      lwbc_pkg::ST_CLEAR: begin
        ram_cmd_o.we   = 1'b1;
        ram_cmd_o.addr = clr_q;
        clr_d          = clr_q + lwbc_pkg::MEM_AW'(1);
      end
      lwbc_pkg::ST_IDLE: begin
        if (acc) begin
          req_d = req_i;
          pos_d = '0;
          if (oob_in) begin
            done_d          = 1'b1;
            rsp_d.read_data = '0;
            rsp_d.status    = lwbc_pkg::STATUS_OOB;
          end
        end
      end
      lwbc_pkg::ST_SCAN: begin
        // A miss leaves the memory read of the address in flight.
        if (!scan_end) begin
          if (st_rsp_i.match) begin
            st_cmd_o.promote   = 1'b1;
            st_cmd_o.prom_pos  = lwbc_pkg::WAY_W'(pos_q);
            st_cmd_o.prom_slot = st_rsp_i.slot;
            st_cmd_o.wr_slot   = st_rsp_i.slot;
            st_cmd_o.wr_data   = req_q.write_data;
            st_cmd_o.entry_we  = (req_q.operation == lwbc_pkg::OP_WRITE);
            done_d             = 1'b1;
            rsp_d.read_data    = (req_q.operation == lwbc_pkg::OP_WRITE) ? '0 : st_rsp_i.data;
            rsp_d.status       = lwbc_pkg::STATUS_DONE;
          end else begin
            pos_d = pos_q + lwbc_pkg::FILL_W'(1);
          end
        end
      end
      lwbc_pkg::ST_FILL: begin
        st_cmd_o.rd_pos   = last_pos;
        st_cmd_o.promote  = 1'b1;
        st_cmd_o.entry_we = 1'b1;
        st_cmd_o.wr_data  = fresh;
        if (evict) begin
          // Write the least recent entry back and reuse its slot.
          ram_cmd_o.we       = 1'b1;
          ram_cmd_o.addr     = lwbc_pkg::MEM_AW'(st_rsp_i.address);
          ram_cmd_o.wdata    = st_rsp_i.data;
          st_cmd_o.prom_pos  = last_pos;
          st_cmd_o.prom_slot = st_rsp_i.slot;
          st_cmd_o.wr_slot   = st_rsp_i.slot;
        end else begin
          st_cmd_o.prom_pos  = lwbc_pkg::WAY_W'(fill_q);
          st_cmd_o.prom_slot = lwbc_pkg::WAY_W'(fill_q);
          st_cmd_o.wr_slot   = lwbc_pkg::WAY_W'(fill_q);
          fill_d             = fill_q + lwbc_pkg::FILL_W'(1);
        end
        done_d          = 1'b1;
        rsp_d.read_data = (req_q.operation == lwbc_pkg::OP_WRITE) ? '0 : ram_rdata_i;
        rsp_d.status    = lwbc_pkg::STATUS_DONE;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwbc_pkg::ST_CLEAR;
      pos_q   <= '0;
      fill_q  <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q  <= lwbc_pkg::WAYS_RESET;
      words_q <= lwbc_pkg::WORDS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lwbc_pkg::REG_WAYS_IN_USE:  ways_q  <= cfg_data_i[lwbc_pkg::WAYS_CFG_W-1:0];
        lwbc_pkg::REG_WORDS_IN_USE: words_q <= cfg_data_i[lwbc_pkg::WORDS_CFG_W-1:0];
        default: ways_q <= ways_q;
      endcase
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks.
  `LWBC_ASSERT(a_fill_bound, (32'(fill_q) <= lwbc_pkg::WAYS), "fill count above way count")
  `LWBC_ASSERT(a_scan_bound, (state_q == lwbc_pkg::ST_SCAN) |-> (pos_q <= fill_q), "scan past fill")
  `LWBC_ASSERT_NEXT(a_fill_hold, (state_q != lwbc_pkg::ST_FILL), $stable(fill_q), "fill moved")
  `LWBC_ASSERT(a_done_cause, done_q |-> $past((state_q != lwbc_pkg::ST_IDLE) || acc), "stray result")

endmodule

`default_nettype wire

### design/lru_write_back_cache_unit.sv
// Out-of-bound address: the result is shown in the cycle after the accepting edge.
// Hit at recency position p: the scan checks positions 0 to p in turn. Miss: every filled
// position is checked, then ST_FILL evicts the least recent entry or takes a free slot.
// The scan steps one recency position per cycle through one shared address comparator.
// Reset clears the backing memory with busy high. A new start is taken in the cycle in which
// done_o is high; results are strobed by done_o for one cycle and the receiver cannot stall.
`default_nettype none

module lru_write_back_cache_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire lwbc_pkg::req_t                   req_i,
  output logic                                  done_o,
  output lwbc_pkg::rsp_t                        rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lwbc_pkg::st_cmd_t            st_cmd;
  lwbc_pkg::st_rsp_t            st_rsp;
  lwbc_pkg::ram_cmd_t           ram_cmd;
  logic [lwbc_pkg::DATA_W-1:0]  ram_rdata;

  // Sequencer.
  lwbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .st_cmd_o    (st_cmd),
    .st_rsp_i    (st_rsp),
    .ram_cmd_o   (ram_cmd),
    .ram_rdata_i (ram_rdata),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  // Entries and recency list.
  lwbc_store u_store (
    .clk_i (clk_i),
    .cmd_i (st_cmd),
    .rsp_o (st_rsp)
  );

  // Backing memory.
  lwbc_ram u_ram (
    .clk_i   (clk_i),
    .cmd_i   (ram_cmd),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

### sim/lru_write_back_cache_unit_test.sv
// Self-checking testbench of the LRU write-back cache unit: directed table, then random phases.
`timescale 1ns / 1ps

module lru_write_back_cache_unit_test;
  import lwbc_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1050;
  localparam int MAX_GAP      = 13;
  localparam int TAIL_CYCLES  = 24;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic {
    ROW_ACCESS,
    ROW_SETUP
  } row_kind_e;

  // One line of the directed table: either an access or a register setting.
  typedef struct {
    row_kind_e             kind;
    req_t                  req;
    bit                    known;
    rsp_t                  rsp;
    logic [CFG_DATA_W-1:0] ways_val;
    logic [CFG_DATA_W-1:0] words_val;
  } stim_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  req_t                  req_i      = '0;
  logic                  done_o;
  rsp_t                  rsp_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow copy of the cache and its backing memory.
  logic [DATA_W-1:0]      mem_words [MEM_DEPTH];
  logic [ADDR_W-1:0]      line_addr [WAYS];
  logic [DATA_W-1:0]      line_data [WAYS];
  int unsigned            lru_order [WAYS];
  int unsigned            lines_filled;
  logic [WAYS_CFG_W-1:0]  ways_reg;
  logic [WORDS_CFG_W-1:0] words_reg;

  rsp_t      pending_rsps [$];
  stim_row_t directed_rows [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned hit_count      = 0;
  int unsigned evict_count    = 0;
  int unsigned oob_count      = 0;
  int unsigned transfer_count = 0;
  int unsigned setting_count  = 0;

  lru_write_back_cache_unit i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .done_o,
    .rsp_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Effective entry limit: zero acts as one, anything above the way count saturates.
  function automatic int unsigned way_cap();
    if (ways_reg == 0) return 1;
    if (ways_reg > WAYS) return WAYS;
    return ways_reg;
  endfunction

  // Effective memory size: anything above the depth saturates.
  function automatic int unsigned word_cap();
    if (words_reg > MEM_DEPTH) return MEM_DEPTH;
    return words_reg;
  endfunction

  // Move the slot at a recency position to the most recent position.
  function automatic void move_to_front(int unsigned pos);
    int unsigned slot;
    slot = lru_order[pos];
    for (int unsigned k = pos; k > 0; k--) lru_order[k] = lru_order[k - 1];
    lru_order[0] = slot;
  endfunction

  // Apply one access to the shadow cache and return the result it should give.
  function automatic rsp_t cache_access(req_t r);
    int unsigned       n;
    int unsigned       lim;
    int unsigned       pos;
    int unsigned       slot;
    bit                hit;
    logic [DATA_W-1:0] fresh;
    rsp_t              res;
    n   = (lines_filled > WAYS) ? WAYS : lines_filled;
    lim = way_cap();
    hit = 1'b0;
    pos = 0;
    res = '0;
    if (r.address >= word_cap()) begin
      oob_count++;
      res.status = STATUS_OOB;
      return res;
    end
    for (int unsigned p = 0; p < n; p++) begin
      if (!hit && line_addr[lru_order[p]] == r.address) begin
        hit = 1'b1;
        pos = p;
      end
    end
    if (hit) begin
      hit_count++;
      move_to_front(pos);
      slot = lru_order[0];
      if (r.operation == OP_WRITE) line_data[slot] = r.write_data;
    end else begin
      fresh = (r.operation == OP_WRITE) ? r.write_data : mem_words[r.address];
      if (n >= lim && n > 0) begin
        // Full: the least recent entry goes back to memory and its slot is reused.
        evict_count++;
        slot = lru_order[n - 1];
        mem_words[line_addr[slot]] = line_data[slot];
        move_to_front(n - 1);
      end else begin
        slot = n;
        lru_order[n] = slot;
        move_to_front(n);
        n++;
      end
      line_addr[slot] = r.address;
      line_data[slot] = fresh;
      lines_filled = n;
    end
    res.status    = STATUS_DONE;
    res.read_data = (r.operation == OP_WRITE) ? '0 : line_data[slot];
    return res;
  endfunction

  // Directed table builders.
  function automatic void add_access(logic op, int unsigned addr, logic [DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_ACCESS, req: '0, known: 1'b0, rsp: '0, ways_val: '0, words_val: '0};
    row.req.operation  = op;
    row.req.address    = addr[ADDR_W-1:0];
    row.req.write_data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(logic op, int unsigned addr, logic [DATA_W-1:0] data,
                                    logic [DATA_W-1:0] rd, logic st);
    stim_row_t row;
    row = '{kind: ROW_ACCESS, req: '0, known: 1'b1, rsp: '0, ways_val: '0, words_val: '0};
    row.req.operation  = op;
    row.req.address    = addr[ADDR_W-1:0];
    row.req.write_data = data;
    row.rsp.read_data  = rd;
    row.rsp.status     = st;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_setup(int unsigned ways_val, int unsigned words_val);
    stim_row_t row;
    row = '{kind: ROW_SETUP, req: '0, known: 1'b0, rsp: '0, ways_val: '0, words_val: '0};
    row.ways_val  = ways_val[CFG_DATA_W-1:0];
    row.words_val = words_val[CFG_DATA_W-1:0];
    directed_rows.push_back(row);
  endfunction

  // Present one request after an idle gap and record its expected result on transfer.
  // Start is left high on return, so a back-to-back request keeps it up.
  task automatic send_request(req_t r, int unsigned gap, bit known, rsp_t known_rsp);
    rsp_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = cache_access(r);
    pending_rsps.push_back(known ? known_rsp : predicted);
    transfer_count++;
  endtask

  // Stop sending and wait until every expected result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers while the block is idle.
  task automatic apply_setup(logic [CFG_DATA_W-1:0] ways_val,
                             logic [CFG_DATA_W-1:0] words_val);
    drain_results();
    while (busy) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WAYS_IN_USE;
    cfg_data_i <= ways_val;
    @(posedge clk_i);
    ways_reg = ways_val[WAYS_CFG_W-1:0];
    cfg_idx_i  <= REG_WORDS_IN_USE;
    cfg_data_i <= words_val;
    @(posedge clk_i);
    words_reg = words_val[WORDS_CFG_W-1:0];
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d results outstanding.", pending_rsps.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsps.size() == 0) begin
        $error("Result transfer with nothing expected: read_data %h status %b",
               rsp_o.read_data, rsp_o.status);
        mismatch_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_o.read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, rsp_o.read_data);
          mismatch_count++;
        end
        if (rsp_o.status !== want.status) begin
          $error("status: expected %b, actual %b", want.status, rsp_o.status);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t   row;
    req_t        r;
    int unsigned ways_pick;
    int unsigned words_pick;
    int unsigned lim;
    int unsigned wl;
    int unsigned span;
    int unsigned base;
    int unsigned phase_len;
    int unsigned sel;
    int unsigned gap;
    int unsigned sent;
    bit          no_idle;
    bit          paused_once;

    for (int i = 0; i < MEM_DEPTH; i++) mem_words[i] = '0;
    for (int i = 0; i < WAYS; i++) begin
      line_addr[i] = '0;
      line_data[i] = '0;
      lru_order[i] = 0;
    end
    lines_filled = 0;
    ways_reg     = WAYS_RESET;
    words_reg    = WORDS_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its memory after reset with busy high.
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // Directed table: memory starts at zero, extremes of data and address, bound errors,
    // and the saturating and zero cases of both registers.
    add_known(OP_READ, 0, '0, '0, STATUS_DONE);
    add_known(OP_READ, 1023, '0, '0, STATUS_DONE);
    add_known(OP_WRITE, 1023, 32'h7FFF_FFFF, '0, STATUS_DONE);
    add_known(OP_READ, 1023, '0, 32'h7FFF_FFFF, STATUS_DONE);
    add_known(OP_WRITE, 0, 32'h8000_0000, '0, STATUS_DONE);
    add_known(OP_READ, 0, 32'hFFFF_FFFF, 32'h8000_0000, STATUS_DONE);
    add_known(OP_WRITE, 512, 32'hFFFF_FFFF, '0, STATUS_DONE);
    add_known(OP_READ, 512, '0, 32'hFFFF_FFFF, STATUS_DONE);
    add_access(OP_READ, 341, '0);
    add_access(OP_WRITE, 682, 32'h5555_AAAA);
    add_setup(16, 1000);
    add_known(OP_READ, 1000, '0, '0, STATUS_OOB);
    add_known(OP_WRITE, 1023, 32'h0000_1234, '0, STATUS_OOB);
    add_access(OP_READ, 999, '0);
    add_setup(16, 0);
    add_known(OP_READ, 0, '0, '0, STATUS_OOB);
    add_setup(16, 2047);
    add_access(OP_READ, 1023, '0);
    // Entry limit dropped below the fill count: each miss evicts one entry.
    add_setup(11'h7E1, 1024);
    add_access(OP_READ, 7, '0);
    add_access(OP_WRITE, 8, 32'h0BAD_F00D);
    add_access(OP_READ, 7, '0);
    add_access(OP_READ, 1023, '0);
    add_setup(0, 1024);
    add_access(OP_WRITE, 9, 32'hCAFE_F00D);
    add_access(OP_READ, 10, '0);
    add_setup(31, 1024);
    add_access(OP_READ, 9, '0);
    add_access(OP_READ, 8, '0);
    add_setup(16, 1024);
    add_access(OP_READ, 341, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_SETUP) begin
        apply_setup(row.ways_val, row.words_val);
      end else begin
        send_request(row.req, $urandom_range(0, MAX_GAP), row.known, row.rsp);
      end
    end

    // Random phases: each picks a register setting, then mostly works a small address
    // window so hits, fills and evictions all happen, with some wide and boundary addresses.
    sent        = 0;
    paused_once = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       ways_pick = 1;
        1:       ways_pick = 0;
        2:       ways_pick = WAYS;
        3:       ways_pick = $urandom_range(WAYS + 1, 31);
        default: ways_pick = $urandom_range(2, WAYS - 1);
      endcase
      case ($urandom_range(0, 7))
        0:       words_pick = 0;
        1:       words_pick = 1;
        2:       words_pick = MEM_DEPTH;
        3:       words_pick = $urandom_range(MEM_DEPTH + 1, 2047);
        4:       words_pick = $urandom_range(2, 40);
        default: words_pick = $urandom_range(41, MEM_DEPTH - 1);
      endcase
      // Upper bits of the entry-limit write are not part of the register.
      apply_setup(CFG_DATA_W'(($urandom_range(0, 63) << WAYS_CFG_W) | ways_pick),
                  CFG_DATA_W'(words_pick));

      lim       = way_cap();
      wl        = word_cap();
      span      = lim + $urandom_range(1, lim + 2);
      base      = (wl > span) ? $urandom_range(0, wl - span) : 0;
      phase_len = (wl == 0) ? 8 : $urandom_range(40, 120);
      no_idle   = ($urandom_range(0, 3) == 0);

      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        r.operation = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          r.address = ADDR_W'(base + $urandom_range(0, span - 1));
        end else if (sel < 17) begin
          r.address = ADDR_W'($urandom);
        end else begin
          r.address = ADDR_W'(($urandom_range(0, 1) != 0 && wl > 0) ? wl - 1 : wl);
        end
        case ($urandom_range(0, 9))
          0:       r.write_data = 32'h8000_0000;
          1:       r.write_data = 32'h7FFF_FFFF;
          2:       r.write_data = 32'hFFFF_FFFF;
          3:       r.write_data = '0;
          default: r.write_data = $urandom;
        endcase
        // Now and then the sender holds off until the block has answered everything.
        if ((!paused_once && i == 5) || $urandom_range(0, 49) == 0) begin
          drain_results();
          paused_once = 1'b1;
        end
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        send_request(r, gap, 1'b0, '0);
        sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d transfers over %0d register settings.", transfer_count, setting_count);
    $display("Seen %0d hits, %0d evictions with write-back, %0d out-of-bound accesses.",
             hit_count, evict_count, oob_count);
    if (mismatch_count == 0 && pending_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
